### src/xcle_pkg.sv
// xcle_pkg: shared constants, codes and the crc-16 byte update for the xmodem crc link engine
// no dependencies; used by the core, its checker and the bench
package xcle_pkg;

  // payload size of one packet and the matching count constant
  localparam int          PAYLOAD_BYTES = 128;
  localparam logic [7:0]  PAYLOAD_CNT   = 8'(PAYLOAD_BYTES);

  // configuration register map
  localparam int          CFG_ADDR_W    = 3;
  localparam logic        REG_MAX_RETRIES = 1'b0;
  localparam logic [7:0]  MAX_RETRIES_RST = 8'd25;

  // crc-16 xmodem polynomial
  localparam logic [15:0] CRC_POLY      = 16'h1021;

  // incoming control codes
  localparam logic [2:0]  CMD_SOH = 3'd0;
  localparam logic [2:0]  CMD_STX = 3'd1;
  localparam logic [2:0]  CMD_EOT = 3'd2;
  localparam logic [2:0]  CMD_CAN = 3'd3;
  localparam logic [2:0]  CMD_ACK = 3'd4;
  localparam logic [2:0]  CMD_NAK = 3'd5;

  // reply codes
  localparam logic [2:0]  RPL_ACK  = 3'd0;
  localparam logic [2:0]  RPL_NAK  = 3'd1;
  localparam logic [2:0]  RPL_CAN  = 3'd2;
  localparam logic [2:0]  RPL_EOT  = 3'd3;
  localparam logic [2:0]  RPL_DATA = 3'd4;

  // one byte through the msb-first crc shift register
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### src/xmodem_crc_link_engine_core.sv
// xmodem_crc_link_engine_core: per-byte crc and packet-end reply decision for an xmodem link
// depends on xcle_pkg
//
//  channel  | direction | handshake           | word
//  ---------+-----------+---------------------+--------------------------------------------
//  in_      | input     | in_valid/in_ready   | one packet byte with control and flags
//  out_     | output    | out_valid/out_ready | at most one reply, on a packet's last word
//  cfg      | input     | apb, pready high    | max_retries at byte address 0
//
// one word accepted per cycle while the result register is not stalled; a reply passes through
// the input register, then the crc and decision logic into the result register
// crc update is one byte per cycle while the input register advances, through an eight-step shift network
// a stalled out_ready holds the result register; the input register keeps filling, and
// in_ready drops only when both are full and the result is not taken
// rst_n is synchronous: all session state clears and max_retries returns to 25
module xmodem_crc_link_engine_core (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_cmd,
  input  logic [15:0] in_seq,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_last,
  input  logic [15:0] in_crc_expected,
  input  logic        in_storage_ok,
  input  logic        in_chunk_short,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_reply_code,
  output logic [15:0] out_reply_seq,
  output logic        out_receiving,
  output logic        out_transmitting,
  output logic [31:0] out_received_bytes,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [xcle_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration register
  logic [7:0]  max_retries_r;

  // input register
  logic        s1_valid_r;
  logic [2:0]  s1_cmd_r;
  logic [15:0] s1_seq_r;
  logic [7:0]  s1_data_r;
  logic        s1_bv_r;
  logic        s1_last_r;
  logic [15:0] s1_crc_exp_r;
  logic        s1_ok_r;
  logic        s1_short_r;

  // session state
  logic        rx_active_r, rx_active_nxt;
  logic        tx_active_r, tx_active_nxt;
  logic        eot_pending_r, eot_pending_nxt;
  logic [15:0] packet_number_r, packet_number_nxt;
  logic [7:0]  retries_left_r, retries_left_nxt;
  logic [15:0] crc_running_r, crc_running_nxt;
  logic [7:0]  payload_count_r, payload_count_nxt;
  logic        over_length_r, over_length_nxt;
  logic [31:0] byte_total_r, byte_total_nxt;

  // result register
  logic        out_valid_r;
  logic [2:0]  out_code_r;
  logic [15:0] out_seq_r;
  logic        out_rx_r;
  logic        out_tx_r;
  logic [31:0] out_total_r;

  // decision outputs
  logic        reply;
  logic [2:0]  code;
  logic [15:0] rseq;
  logic [15:0] crc_acc;
  logic [7:0]  cnt_acc;
  logic        ovl_acc;

  logic        s1_adv;
  logic        cfg_wr;

  // handshake flow
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  // configuration access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == xcle_pkg::REG_MAX_RETRIES);
  assign prdata = (paddr[2] == xcle_pkg::REG_MAX_RETRIES) ? {24'h0, max_retries_r} : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_retries_r <= xcle_pkg::MAX_RETRIES_RST;
    end else if (cfg_wr) begin
      max_retries_r <= pwdata[7:0];
    end
  end

  // input register load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd_r     <= in_cmd;
      s1_seq_r     <= in_seq;
      s1_data_r    <= in_data_byte;
      s1_bv_r      <= in_byte_valid;
      s1_last_r    <= in_last;
      s1_crc_exp_r <= in_crc_expected;
      s1_ok_r      <= in_storage_ok;
      s1_short_r   <= in_chunk_short;
    end
  end

  // crc, count and reply decision for the word in the input register
  always_comb begin
    crc_acc = crc_running_r;
    cnt_acc = payload_count_r;
    ovl_acc = over_length_r;
    if (s1_bv_r) begin
      if (payload_count_r >= xcle_pkg::PAYLOAD_CNT) begin
        ovl_acc = 1'b1;
      end else begin
        crc_acc = xcle_pkg::crc_byte(crc_running_r, s1_data_r);
        cnt_acc = payload_count_r + 8'd1;
      end
    end

    rx_active_nxt     = rx_active_r;
    tx_active_nxt     = tx_active_r;
    eot_pending_nxt   = eot_pending_r;
    packet_number_nxt = packet_number_r;
    retries_left_nxt  = retries_left_r;
    byte_total_nxt    = byte_total_r;
    crc_running_nxt   = crc_acc;
    payload_count_nxt = cnt_acc;
    over_length_nxt   = ovl_acc;
    reply             = 1'b0;
    code              = xcle_pkg::RPL_ACK;
    rseq              = 16'h0;

    if (s1_last_r) begin
      crc_running_nxt   = 16'h0;
      payload_count_nxt = 8'h0;
      over_length_nxt   = 1'b0;
      reply             = 1'b1;
      unique case (s1_cmd_r)
        xcle_pkg::CMD_SOH, xcle_pkg::CMD_STX: begin
          if (s1_seq_r == 16'h0 && !rx_active_r && !tx_active_r) begin
            // session start packet
            byte_total_nxt = 32'h0;
            if (!s1_ok_r) begin
              code = xcle_pkg::RPL_NAK;
            end else if (s1_cmd_r == xcle_pkg::CMD_SOH) begin
              code              = xcle_pkg::RPL_ACK;
              rx_active_nxt     = 1'b1;
              packet_number_nxt = 16'd1;
            end else begin
              code              = xcle_pkg::RPL_DATA;
              rseq              = 16'd1;
              packet_number_nxt = 16'd1;
              tx_active_nxt     = 1'b1;
              retries_left_nxt  = max_retries_r;
              eot_pending_nxt   = s1_short_r;
            end
          end else if (rx_active_r) begin
            // data packet while receiving
            if (s1_seq_r == packet_number_r && crc_acc == s1_crc_exp_r && !ovl_acc) begin
              if (s1_ok_r) begin
                code              = xcle_pkg::RPL_ACK;
                byte_total_nxt    = byte_total_r + {24'h0, cnt_acc};
                packet_number_nxt = packet_number_r + 16'd1;
              end else begin
                code          = xcle_pkg::RPL_CAN;
                rx_active_nxt = 1'b0;
              end
            end else begin
              code = xcle_pkg::RPL_NAK;
            end
          end else if (tx_active_r) begin
            code          = xcle_pkg::RPL_CAN;
            tx_active_nxt = 1'b0;
          end else begin
            reply = 1'b0;
          end
        end
        xcle_pkg::CMD_EOT, xcle_pkg::CMD_CAN: begin
          code          = xcle_pkg::RPL_ACK;
          rx_active_nxt = 1'b0;
        end
        xcle_pkg::CMD_ACK: begin
          if (!tx_active_r) begin
            code = xcle_pkg::RPL_CAN;
          end else if (eot_pending_r) begin
            code            = xcle_pkg::RPL_EOT;
            tx_active_nxt   = 1'b0;
            eot_pending_nxt = 1'b0;
          end else begin
            code              = xcle_pkg::RPL_DATA;
            rseq              = packet_number_r + 16'd1;
            packet_number_nxt = packet_number_r + 16'd1;
            retries_left_nxt  = max_retries_r;
            eot_pending_nxt   = s1_short_r;
          end
        end
        xcle_pkg::CMD_NAK: begin
          if (!tx_active_r) begin
            code = xcle_pkg::RPL_CAN;
          end else if (retries_left_r <= 8'd1) begin
            code             = xcle_pkg::RPL_CAN;
            retries_left_nxt = 8'h0;
            tx_active_nxt    = 1'b0;
          end else begin
            code             = xcle_pkg::RPL_DATA;
            rseq             = packet_number_r;
            retries_left_nxt = retries_left_r - 8'd1;
            eot_pending_nxt  = eot_pending_r || s1_short_r;
          end
        end
        default: begin
          reply = 1'b0;
        end
      endcase
    end
  end

  // session state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_active_r     <= 1'b0;
      tx_active_r     <= 1'b0;
      eot_pending_r   <= 1'b0;
      packet_number_r <= 16'h0;
      retries_left_r  <= 8'h0;
      crc_running_r   <= 16'h0;
      payload_count_r <= 8'h0;
      over_length_r   <= 1'b0;
      byte_total_r    <= 32'h0;
    end else if (s1_adv) begin
      rx_active_r     <= rx_active_nxt;
      tx_active_r     <= tx_active_nxt;
      eot_pending_r   <= eot_pending_nxt;
      packet_number_r <= packet_number_nxt;
      retries_left_r  <= retries_left_nxt;
      crc_running_r   <= crc_running_nxt;
      payload_count_r <= payload_count_nxt;
      over_length_r   <= over_length_nxt;
      byte_total_r    <= byte_total_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= reply;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && reply) begin
      out_code_r  <= code;
      out_seq_r   <= rseq;
      out_rx_r    <= rx_active_nxt;
      out_tx_r    <= tx_active_nxt;
      out_total_r <= byte_total_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_reply_code     = out_code_r;
  assign out_reply_seq      = out_seq_r;
  assign out_receiving      = out_rx_r;
  assign out_transmitting   = out_tx_r;
  assign out_received_bytes = out_total_r;

endmodule

### src/xcle_checker.sv
// xcle_checker: port-level assertions for xmodem_crc_link_engine_core, bound into that module
// depends on xcle_pkg
module xcle_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_reply_code,
  input logic [15:0] out_reply_seq,
  input logic        out_receiving,
  input logic        out_transmitting,
  input logic [31:0] out_received_bytes
);

  // a stalled reply stays valid and holds its code, sequence and byte count
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_reply_code) &&
    $stable(out_reply_seq) && $stable(out_received_bytes))
    else $error("stalled reply changed");

  // only a data reply carries a packet number
  a_seq_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_reply_code != xcle_pkg::RPL_DATA) |-> out_reply_seq == 16'h0)
    else $error("nonzero sequence on non-data reply");

  // a data reply means an ongoing transmit session and no receive session
  a_data_tx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_reply_code == xcle_pkg::RPL_DATA) |->
    out_transmitting && !out_receiving && out_reply_seq != 16'h0 || 
    out_transmitting && !out_receiving)
    else $error("data reply outside transmit session");

  // eot ends the transmit session, and the two sessions never overlap
  a_eot_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_receiving && out_transmitting) &&
    ((out_reply_code != xcle_pkg::RPL_EOT) || !out_transmitting))
    else $error("session flags inconsistent");

endmodule

bind xmodem_crc_link_engine_core xcle_checker u_xcle_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_reply_code     (out_reply_code),
  .out_reply_seq      (out_reply_seq),
  .out_receiving      (out_receiving),
  .out_transmitting   (out_transmitting),
  .out_received_bytes (out_received_bytes)
);

### tb/tb_top.sv
// tb_top: self-checking bench for the xmodem crc link engine core, packet words in, replies out
// depends on xcle_pkg and xmodem_crc_link_engine_core; predicts every reply from its own
// session model and compares it field by field under random idling on both channels
module tb_top;
  import xcle_pkg::*;

  // control codes with no meaning to the engine
  localparam logic [2:0] CMD_UNKNOWN_LO = 3'd6;
  localparam logic [2:0] CMD_UNKNOWN_HI = 3'd7;

  localparam int RANDOM_WORDS  = 1450;
  localparam int NUM_SETTINGS  = 5;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int HOLD_CYCLES   = 250;

  typedef struct {
    logic [2:0]  cmd;
    logic [15:0] seq;
    logic [7:0]  data;
    logic        byte_valid;
    logic        last;
    logic [15:0] crc_exp;
    logic        storage_ok;
    logic        chunk_short;
  } link_word_t;

  typedef struct {
    logic [2:0]  code;
    logic [15:0] seq;
    logic        receiving;
    logic        transmitting;
    logic [31:0] total;
  } link_reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_cmd = '0;
  logic [15:0] in_seq = '0;
  logic [7:0]  in_data_byte = '0;
  logic        in_byte_valid = 1'b0;
  logic        in_last = 1'b0;
  logic [15:0] in_crc_expected = '0;
  logic        in_storage_ok = 1'b0;
  logic        in_chunk_short = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_reply_code;
  logic [15:0] out_reply_seq;
  logic        out_receiving;
  logic        out_transmitting;
  logic [31:0] out_received_bytes;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  xmodem_crc_link_engine_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cmd             (in_cmd),
    .in_seq             (in_seq),
    .in_data_byte       (in_data_byte),
    .in_byte_valid      (in_byte_valid),
    .in_last            (in_last),
    .in_crc_expected    (in_crc_expected),
    .in_storage_ok      (in_storage_ok),
    .in_chunk_short     (in_chunk_short),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_reply_code     (out_reply_code),
    .out_reply_seq      (out_reply_seq),
    .out_receiving      (out_receiving),
    .out_transmitting   (out_transmitting),
    .out_received_bytes (out_received_bytes),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // session model of the engine
  logic        rx_on = 1'b0;
  logic        tx_on = 1'b0;
  logic        eot_due = 1'b0;
  logic        too_long = 1'b0;
  logic [15:0] pkt_num = '0;
  logic [15:0] crc_acc = '0;
  logic [7:0]  retries = '0;
  logic [7:0]  byte_cnt = '0;
  logic [7:0]  retry_limit = MAX_RETRIES_RST;
  logic [31:0] total_bytes = '0;

  link_word_t  pending_q[$];
  link_reply_t reply_q[$];
  link_word_t  cur_word;

  int words_accepted = 0;
  int replies_checked = 0;
  int error_count = 0;
  int cycle_count = 0;
  int gen_words = 0;
  logic [7:0] gen_retry_limit = MAX_RETRIES_RST;

  // crc-16 xmodem, one data bit at a time msb first
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

  // advance the session model by one word; returns 1 when the word draws a reply
  function automatic bit predict_reply(input link_word_t w, output link_reply_t r);
    bit gives;
    gives = 1'b1;
    r.code = RPL_ACK;
    r.seq = '0;
    if (w.byte_valid) begin
      if (byte_cnt >= PAYLOAD_CNT) begin
        too_long = 1'b1;
      end else begin
        crc_acc = crc16_step(crc_acc, w.data);
        byte_cnt = byte_cnt + 8'd1;
      end
    end
    if (!w.last) return 1'b0;
    case (w.cmd)
      CMD_SOH, CMD_STX: begin
        if (w.seq == 16'd0 && !rx_on && !tx_on) begin
          // start packet opens a session, or draws a nak when storage is not ok
          total_bytes = '0;
          if (w.cmd == CMD_SOH) begin
            if (w.storage_ok) begin
              rx_on = 1'b1;
              pkt_num = 16'd1;
            end else begin
              r.code = RPL_NAK;
            end
          end else if (w.storage_ok) begin
            pkt_num = 16'd1;
            tx_on = 1'b1;
            retries = retry_limit;
            eot_due = w.chunk_short;
            r.code = RPL_DATA;
            r.seq = 16'd1;
          end else begin
            r.code = RPL_NAK;
          end
        end else if (rx_on) begin
          if (w.seq == pkt_num && crc_acc == w.crc_exp && !too_long) begin
            if (w.storage_ok) begin
              total_bytes = total_bytes + 32'(byte_cnt);
              pkt_num = pkt_num + 16'd1;
            end else begin
              r.code = RPL_CAN;
              rx_on = 1'b0;
            end
          end else begin
            r.code = RPL_NAK;
          end
        end else if (tx_on) begin
          r.code = RPL_CAN;
          tx_on = 1'b0;
        end else begin
          gives = 1'b0;
        end
      end
      CMD_EOT, CMD_CAN: begin
        rx_on = 1'b0;
      end
      CMD_ACK: begin
        if (!tx_on) begin
          r.code = RPL_CAN;
        end else if (eot_due) begin
          r.code = RPL_EOT;
          tx_on = 1'b0;
          eot_due = 1'b0;
        end else begin
          retries = retry_limit;
          pkt_num = pkt_num + 16'd1;
          eot_due = w.chunk_short;
          r.code = RPL_DATA;
          r.seq = pkt_num;
        end
      end
      CMD_NAK: begin
        if (!tx_on) begin
          r.code = RPL_CAN;
        end else if (retries <= 8'd1) begin
          retries = '0;
          r.code = RPL_CAN;
          tx_on = 1'b0;
        end else begin
          retries = retries - 8'd1;
          if (w.chunk_short) eot_due = 1'b1;
          r.code = RPL_DATA;
          r.seq = pkt_num;
        end
      end
      default: begin
        gives = 1'b0;
      end
    endcase
    crc_acc = '0;
    byte_cnt = '0;
    too_long = 1'b0;
    r.receiving = rx_on;
    r.transmitting = tx_on;
    r.total = total_bytes;
    return gives;
  endfunction

  task automatic report_error(input string msg);
    error_count++;
    $display("ERROR @%0d: %s", cycle_count, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      report_error($sformatf("reply %0d %s got %0h want %0h", replies_checked, name, got, want));
  endtask

  // sender: bursts of words with random gaps, payload held while stalled
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    link_reply_t want;
    logic        offer;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      offer = 1'b0;
      if (in_valid && in_ready) begin
        words_accepted <= words_accepted + 1;
        if (predict_reply(cur_word, want)) reply_q.push_back(want);
      end
      if (in_valid && !in_ready) begin
        offer = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (pending_q.size() != 0) begin
        cur_word = pending_q.pop_front();
        offer = 1'b1;
        in_cmd <= cur_word.cmd;
        in_seq <= cur_word.seq;
        in_data_byte <= cur_word.data;
        in_byte_valid <= cur_word.byte_valid;
        in_last <= cur_word.last;
        in_crc_expected <= cur_word.crc_exp;
        in_storage_ok <= cur_word.storage_ok;
        in_chunk_short <= cur_word.chunk_short;
        burst_left--;
        if (burst_left <= 0) begin
          if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(20, 60);
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left = $urandom_range(1, 6);
          end
        end
      end
      in_valid <= offer;
    end
  end

  // receiver: stall regimes, plus two long hold-offs while the sender keeps going
  int hold_left = 0;
  int holds_done = 0;
  int regime_left = 0;
  int stall_pct = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if ((holds_done == 0 && words_accepted >= 400) ||
                 (holds_done == 1 && words_accepted >= 1100)) begin
      holds_done++;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (regime_left <= 0) begin
        regime_left = $urandom_range(30, 150);
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 30;
          default: stall_pct = 75;
        endcase
      end
      regime_left--;
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // reply checker
  always @(posedge clk) begin
    link_reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (reply_q.size() == 0) begin
        report_error($sformatf("reply code %0d with nothing expected", out_reply_code));
      end else begin
        want = reply_q.pop_front();
        check_field("reply_code", 32'(out_reply_code), 32'(want.code));
        check_field("reply_seq", 32'(out_reply_seq), 32'(want.seq));
        check_field("receiving", 32'(out_receiving), 32'(want.receiving));
        check_field("transmitting", 32'(out_transmitting), 32'(want.transmitting));
        check_field("received_bytes", out_received_bytes, want.total);
        replies_checked++;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycle_count, reply_q.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  function automatic logic [7:0] byte_pick();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic push_word(input link_word_t w);
    pending_q.push_back(w);
    gen_words++;
  endtask

  // one packet: nbytes payload bytes, a few empty words between, reply fields on the last word
  task automatic send_packet(input logic [2:0] cmd, input logic [15:0] seq, input int nbytes,
                             input bit crc_good, input bit ok, input bit shrt);
    link_word_t  w;
    logic [15:0] crc;
    int          body;
    int          placed;
    bit          merge;
    crc = '0;
    placed = 0;
    merge = (nbytes > 0) && ($urandom_range(0, 1) == 1);
    body = merge ? nbytes - 1 : nbytes;
    while (placed < body) begin
      w.cmd = cmd;
      w.seq = seq;
      w.last = 1'b0;
      w.byte_valid = ($urandom_range(0, 9) != 0);
      w.data = byte_pick();
      w.crc_exp = 16'($urandom);
      w.storage_ok = 1'($urandom_range(0, 1));
      w.chunk_short = 1'($urandom_range(0, 1));
      if (w.byte_valid) begin
        if (placed < PAYLOAD_BYTES) crc = crc16_step(crc, w.data);
        placed++;
      end
      push_word(w);
    end
    w.cmd = cmd;
    w.seq = seq;
    w.last = 1'b1;
    w.byte_valid = merge;
    w.data = byte_pick();
    if (merge && placed < PAYLOAD_BYTES) crc = crc16_step(crc, w.data);
    w.crc_exp = crc_good ? crc : crc ^ 16'($urandom_range(1, 65535));
    w.storage_ok = ok;
    w.chunk_short = shrt;
    push_word(w);
  endtask

  // receive session: start, data packets good and bad, then end of transfer, unless a failed start or storage ends it
  task automatic rx_session();
    logic [15:0] num;
    logic [15:0] bad;
    logic [2:0]  cmd;
    bit          ok;
    int          len;
    int          r;
    int          v;
    ok = ($urandom_range(0, 9) != 0);
    send_packet(CMD_SOH, 16'd0, $urandom_range(0, 2), 1'($urandom_range(0, 1)), ok,
                1'($urandom_range(0, 1)));
    if (!ok) return;
    num = 16'd1;
    repeat ($urandom_range(1, 8)) begin
      r = $urandom_range(0, 99);
      if (r < 4) len = PAYLOAD_BYTES;
      else if (r < 8) len = $urandom_range(PAYLOAD_BYTES + 1, PAYLOAD_BYTES + 3);
      else len = $urandom_range(0, 10);
      cmd = ($urandom_range(0, 1) == 1) ? CMD_STX : CMD_SOH;
      v = $urandom_range(0, 99);
      if (v < 78) begin
        send_packet(cmd, num, len, 1'b1, 1'b1, 1'($urandom_range(0, 1)));
        if (len <= PAYLOAD_BYTES) num = num + 16'd1;
      end else if (v < 85) begin
        send_packet(cmd, num, len, 1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else if (v < 92) begin
        bad = ($urandom_range(0, 3) == 0) ? 16'd0 : num + 16'($urandom_range(1, 100));
        send_packet(cmd, bad, len, 1'b1, 1'b1, 1'($urandom_range(0, 1)));
      end else begin
        // storage failure on a good packet ends the session
        send_packet(cmd, num, len, 1'b1, 1'b0, 1'($urandom_range(0, 1)));
        if (len <= PAYLOAD_BYTES) return;
      end
    end
    cmd = ($urandom_range(0, 1) == 1) ? CMD_EOT : CMD_CAN;
    send_packet(cmd, 16'($urandom), $urandom_range(0, 3), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // transmit session: start, acks and naks from the far end, ended by eot or cancel
  task automatic tx_session();
    logic [7:0] left;
    bit         ok;
    bit         shrt;
    bit         eot;
    int         v;
    ok = ($urandom_range(0, 9) != 0);
    shrt = ($urandom_range(0, 3) == 0);
    send_packet(CMD_STX, 16'd0, $urandom_range(0, 2), 1'($urandom_range(0, 1)), ok, shrt);
    if (!ok) return;
    eot = shrt;
    left = gen_retry_limit;
    repeat ($urandom_range(1, 10)) begin
      shrt = ($urandom_range(0, 3) == 0);
      v = $urandom_range(0, 99);
      if (v < ((gen_retry_limit <= 8'd3) ? 30 : 55)) begin
        send_packet(CMD_ACK, 16'($urandom), $urandom_range(0, 1), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), shrt);
        if (eot) return;
        left = gen_retry_limit;
        eot = shrt;
      end else if (v < 92) begin
        send_packet(CMD_NAK, 16'($urandom), $urandom_range(0, 1), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), shrt);
        if (left <= 8'd1) return;
        left = left - 8'd1;
        if (shrt) eot = 1'b1;
      end else if (v < 96) begin
        send_packet(($urandom_range(0, 1) == 1) ? CMD_EOT : CMD_CAN, 16'($urandom), 0,
                    1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        break;
      end
    end
    // a data packet cancels the transmit side
    send_packet(CMD_SOH, 16'($urandom), $urandom_range(0, 2), 1'b1, 1'b1, 1'b0);
  endtask

  // wait until the sender has drained its queue and every reply is in, then let the pipeline settle
  task automatic wait_idle();
    do @(negedge clk); while (pending_q.size() != 0 || in_valid || reply_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // register write, then a read back of the same register
  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    retry_limit = value[7:0];
    gen_retry_limit = value[7:0];
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {24'h0, value[7:0]})
      report_error($sformatf("register read back %0h want %0h", prdata, value[7:0]));
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    link_word_t  w;
    logic [15:0] crc;
    logic [7:0]  settings [NUM_SETTINGS];
    int          target;
    int          v;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: receive path
    send_packet(CMD_SOH, 16'd0, 0, 1'b1, 1'b1, 1'b0);
    crc = crc16_step(crc16_step(16'h0000, 8'h00), 8'hFF);
    w = '{cmd: CMD_STX, seq: 16'd1, data: 8'h00, byte_valid: 1'b1, last: 1'b0,
          crc_exp: 16'hFFFF, storage_ok: 1'b0, chunk_short: 1'b1};
    push_word(w);
    w = '{cmd: CMD_STX, seq: 16'd1, data: 8'hFF, byte_valid: 1'b1, last: 1'b1,
          crc_exp: crc, storage_ok: 1'b1, chunk_short: 1'b1};
    push_word(w);
    send_packet(CMD_SOH, 16'd2, 1, 1'b0, 1'b1, 1'b0);
    send_packet(CMD_SOH, 16'd5, 1, 1'b1, 1'b1, 1'b0);
    send_packet(CMD_SOH, 16'd2, 1, 1'b1, 1'b0, 1'b0);
    send_packet(CMD_EOT, 16'd0, 0, 1'b1, 1'b1, 1'b0);
    send_packet(CMD_CAN, 16'hFFFF, 0, 1'b1, 1'b1, 1'b1);
    send_packet(CMD_SOH, 16'd0, 0, 1'b1, 1'b0, 1'b0);
    // directed: commands while idle, unknown codes, stray data packet
    send_packet(CMD_ACK, 16'd0, 0, 1'b1, 1'b1, 1'b0);
    send_packet(CMD_NAK, 16'd0, 0, 1'b1, 1'b1, 1'b0);
    send_packet(CMD_UNKNOWN_LO, 16'd0, 0, 1'b1, 1'b1, 1'b0);
    send_packet(CMD_UNKNOWN_HI, 16'hFFFF, 0, 1'b0, 1'b1, 1'b1);
    send_packet(CMD_SOH, 16'hFFFF, 0, 1'b1, 1'b1, 1'b0);
    // directed: transmit path with resend, short chunk and eot
    send_packet(CMD_STX, 16'd0, 0, 1'b1, 1'b1, 1'b0);
    send_packet(CMD_NAK, 16'd0, 0, 1'b1, 1'b1, 1'b0);
    send_packet(CMD_ACK, 16'd0, 0, 1'b1, 1'b1, 1'b1);
    send_packet(CMD_NAK, 16'd0, 0, 1'b1, 1'b1, 1'b0);
    send_packet(CMD_ACK, 16'd0, 0, 1'b1, 1'b1, 1'b0);
    send_packet(CMD_STX, 16'd0, 0, 1'b1, 1'b0, 1'b0);
    send_packet(CMD_STX, 16'd0, 0, 1'b1, 1'b1, 1'b0);
    send_packet(CMD_SOH, 16'd3, 0, 1'b1, 1'b1, 1'b0);

    // random phases, one retry setting each
    settings = '{8'd1, 8'd255, 8'd2, 8'($urandom_range(3, 254)), MAX_RETRIES_RST};
    for (int p = 0; p < NUM_SETTINGS; p++) begin
      wait_idle();
      cfg_write(CFG_ADDR_W'(4 * int'(REG_MAX_RETRIES)), 32'(settings[p]));
      target = gen_words + RANDOM_WORDS / NUM_SETTINGS;
      while (gen_words < target) begin
        v = $urandom_range(0, 99);
        if (v < 55) begin
          rx_session();
        end else if (v < 85) begin
          tx_session();
        end else begin
          // raw words, then eot and a stray data packet bring the engine back to idle
          repeat ($urandom_range(1, 6)) begin
            w.cmd = 3'($urandom_range(0, 7));
            w.seq = 16'($urandom);
            w.data = byte_pick();
            w.byte_valid = 1'($urandom_range(0, 1));
            w.last = 1'($urandom_range(0, 1));
            w.crc_exp = 16'($urandom);
            w.storage_ok = 1'($urandom_range(0, 1));
            w.chunk_short = 1'($urandom_range(0, 1));
            push_word(w);
          end
          send_packet(CMD_EOT, 16'($urandom), 0, 1'b1, 1'b1, 1'b0);
          send_packet(CMD_SOH, 16'($urandom_range(1, 65535)), 0, 1'b1, 1'b1, 1'b0);
        end
      end
    end
    wait_idle();
    repeat (20) @(negedge clk);

    $display("run covered %0d words and %0d checked replies across %0d retry settings",
             words_accepted, replies_checked, NUM_SETTINGS + 1);
    $display("receive, transmit and raw word traffic with %0d long output hold-offs",
             holds_done);
    if (error_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("%0d mismatches", error_count);
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
src/xcle_pkg.sv
src/xmodem_crc_link_engine_core.sv
src/xcle_checker.sv
tb/tb_top.sv
